FILE: rtl/lfr_pkg.sv
// Shared types and constants for the linear fractional resampler.
package lfr_pkg;

    // Phase is unsigned Q2.30, carried with one guard bit while it advances
    localparam int PHASE_WIDTH = 33;
    localparam int STEP_WIDTH  = 32;

    localparam logic [PHASE_WIDTH-1:0] PHASE_ONE        = 33'h0_4000_0000;
    localparam logic [STEP_WIDTH-1:0]  STEP_MIN         = 32'h0400_0000;
    localparam logic [STEP_WIDTH-1:0]  PHASE_STEP_RESET = 32'h4000_0000;

    // Weight is phase[29:14], unsigned Q0.16
    localparam int WEIGHT_LSB   = 14;
    localparam int WEIGHT_WIDTH = 16;
    localparam int ROUND_HALF   = 32768;

    // Entries in the queue between front and back
    localparam int QUEUE_DEPTH = 4;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EVAL,
        S_EMIT
    } t_back_state;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

endpackage

FILE: rtl/lfr_front.sv
// Front end: takes input samples, tracks history and priming, builds jobs.
module lfr_front #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int JOB_WIDTH    = 4 * SAMPLE_WIDTH + 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_valid,
    output logic                             o_ready,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_sample_i,
    input  logic signed [SAMPLE_WIDTH-1:0]   i_sample_q,
    input  logic                             i_restart,
    input  lfr_pkg::t_queue_status           i_queue_status,
    output logic                             o_push,
    output logic [JOB_WIDTH-1:0]             o_job
);
    import lfr_pkg::*;

    logic                           r_primed, n_primed;
    logic                           r_clr_pend, n_clr_pend;
    logic signed [SAMPLE_WIDTH-1:0] r_prev_i, r_prev_q;
    logic                           w_accept;
    logic                           w_primed_eff;

    assign o_ready      = !i_queue_status.full;
    assign w_accept     = i_valid && o_ready;
    assign w_primed_eff = r_primed && !i_restart;
    assign o_push       = w_accept && w_primed_eff;
    // job: prev_i, prev_q, cur_i, cur_q, phase clear, from the low bits up
    assign o_job        = {r_clr_pend, i_sample_q, i_sample_i, r_prev_q, r_prev_i};

    always_comb begin
        n_primed   = r_primed;
        n_clr_pend = r_clr_pend;
        if (w_accept) begin
            n_primed = 1'b1;
            if (i_restart) begin
                n_clr_pend = 1'b1;
            end else if (w_primed_eff) begin
                n_clr_pend = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_primed   <= 1'b0;
            r_clr_pend <= 1'b0;
        end else begin
            r_primed   <= n_primed;
            r_clr_pend <= n_clr_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prev_i <= '0;
            r_prev_q <= '0;
        end else if (w_accept) begin
            r_prev_i <= i_sample_i;
            r_prev_q <= i_sample_q;
        end
    end

endmodule

FILE: rtl/lfr_job_queue.sv
// Small register queue holding interpolation jobs between front and back.
module lfr_job_queue #(
    parameter int WIDTH = 65,
    parameter int DEPTH = 4
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_push,
    input  logic [WIDTH-1:0]         i_data,
    input  logic                     i_pop,
    output logic [WIDTH-1:0]         o_data,
    output lfr_pkg::t_queue_status   o_status
);
    import lfr_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [CNT_W-1:0] r_count;
    logic             w_push, w_pop;

    assign o_status.full  = (r_count == CNT_W'(DEPTH));
    assign o_status.empty = (r_count == '0);
    assign w_push = i_push && !o_status.full;
    assign w_pop  = i_pop && !o_status.empty;
    assign o_data = r_mem[r_rd_ptr];

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        ptr_inc = (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (w_push) r_wr_ptr <= ptr_inc(r_wr_ptr);
            if (w_pop)  r_rd_ptr <= ptr_inc(r_rd_ptr);
            if (w_push && !w_pop)      r_count <= r_count + CNT_W'(1);
            else if (w_pop && !w_push) r_count <= r_count - CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) r_mem[r_wr_ptr] <= i_data;
    end

endmodule

FILE: rtl/lfr_back.sv
// Back end: steps the phase, interpolates I/Q and drives the output register.
module lfr_back #(
    parameter int SAMPLE_WIDTH = 16,
    parameter int JOB_WIDTH    = 4 * SAMPLE_WIDTH + 1
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [lfr_pkg::STEP_WIDTH-1:0]   i_cfg_data,
    input  lfr_pkg::t_queue_status           i_queue_status,
    input  logic [JOB_WIDTH-1:0]             i_job,
    output logic                             o_pop,
    output logic                             o_valid,
    input  logic                             i_ready,
    output logic signed [SAMPLE_WIDTH-1:0]   o_out_i,
    output logic signed [SAMPLE_WIDTH-1:0]   o_out_q,
    output logic                             o_last
);
    import lfr_pkg::*;

    localparam int DIFF_W = SAMPLE_WIDTH + 1;
    localparam int PROD_W = DIFF_W + WEIGHT_WIDTH + 1;

    t_back_state r_state, n_state;

    logic [STEP_WIDTH-1:0]          r_step;
    logic [PHASE_WIDTH-1:0]         r_ph, n_ph;
    logic signed [SAMPLE_WIDTH-1:0] r_prev_i, r_prev_q;
    logic signed [DIFF_W-1:0]       r_diff_i, r_diff_q;
    logic signed [PROD_W-1:0]       r_prod_i, r_prod_q;
    logic                           r_last;
    logic                           r_out_valid;

    logic                           w_load_prod, w_load_out, w_adv, w_end;
    logic                           w_below;
    logic [STEP_WIDTH-1:0]          w_step;
    logic [PHASE_WIDTH-1:0]         w_sum, w_ph_end;
    logic [WEIGHT_WIDTH-1:0]        w_weight;

    logic signed [SAMPLE_WIDTH-1:0] w_job_prev_i, w_job_prev_q;
    logic signed [SAMPLE_WIDTH-1:0] w_job_cur_i, w_job_cur_q;
    logic                           w_job_clr;
    logic signed [PROD_W-1:0]       w_rnd_i, w_rnd_q;
    logic signed [PROD_W-1:0]       w_sh_i, w_sh_q;

    assign w_job_prev_i = i_job[0 +: SAMPLE_WIDTH];
    assign w_job_prev_q = i_job[SAMPLE_WIDTH +: SAMPLE_WIDTH];
    assign w_job_cur_i  = i_job[2*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    assign w_job_cur_q  = i_job[3*SAMPLE_WIDTH +: SAMPLE_WIDTH];
    assign w_job_clr    = i_job[4*SAMPLE_WIDTH];

    assign w_step   = (r_step < STEP_MIN) ? STEP_MIN : r_step;
    assign w_below  = (r_ph < PHASE_ONE);
    assign w_sum    = r_ph + {1'b0, w_step};
    assign w_ph_end = r_ph - PHASE_ONE;
    assign w_weight = r_ph[WEIGHT_LSB +: WEIGHT_WIDTH];

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (!i_queue_status.empty) n_state = S_EVAL;
            end
            S_EVAL: begin
                n_state = w_below ? S_EMIT : S_IDLE;
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    if (!r_last)                    n_state = S_EVAL;
                    else if (!i_queue_status.empty) n_state = S_EVAL;
                    else                            n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // control outputs
    always_comb begin
        o_pop       = 1'b0;
        w_load_prod = 1'b0;
        w_load_out  = 1'b0;
        w_adv       = 1'b0;
        w_end       = 1'b0;
        case (r_state)
            S_IDLE: begin
                o_pop = !i_queue_status.empty;
            end
            S_EVAL: begin
                if (w_below) begin
                    w_load_prod = 1'b1;
                    w_adv       = 1'b1;
                end else begin
                    w_end = 1'b1;
                end
            end
            S_EMIT: begin
                if (!r_out_valid || i_ready) begin
                    w_load_out = 1'b1;
                    if (r_last) begin
                        w_end = 1'b1;
                        o_pop = !i_queue_status.empty;
                    end
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_ph = r_ph;
        if (o_pop) begin
            if (w_job_clr)  n_ph = '0;
            else if (w_end) n_ph = w_ph_end;
        end else if (w_end) begin
            n_ph = w_ph_end;
        end else if (w_adv) begin
            n_ph = w_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_ph        <= '0;
            r_step      <= PHASE_STEP_RESET;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_ph    <= n_ph;
            if (i_cfg_we) r_step <= i_cfg_data;
            if (w_load_out)   r_out_valid <= 1'b1;
            else if (i_ready) r_out_valid <= 1'b0;
        end
    end

    // job operands
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_prev_i <= w_job_prev_i;
            r_prev_q <= w_job_prev_q;
            r_diff_i <= DIFF_W'(w_job_cur_i) - DIFF_W'(w_job_prev_i);
            r_diff_q <= DIFF_W'(w_job_cur_q) - DIFF_W'(w_job_prev_q);
        end
    end

    // weighted difference, one multiplier per rail
    always_ff @(posedge i_clk) begin
        if (w_load_prod) begin
            r_prod_i <= r_diff_i * $signed({1'b0, w_weight});
            r_prod_q <= r_diff_q * $signed({1'b0, w_weight});
            r_last   <= (w_sum >= PHASE_ONE);
        end
    end

    // round half up, then add history; result stays between prev and cur
    assign w_rnd_i = r_prod_i + PROD_W'(ROUND_HALF);
    assign w_rnd_q = r_prod_q + PROD_W'(ROUND_HALF);
    assign w_sh_i  = w_rnd_i >>> WEIGHT_WIDTH;
    assign w_sh_q  = w_rnd_q >>> WEIGHT_WIDTH;

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            o_out_i <= w_sh_i[SAMPLE_WIDTH-1:0] + r_prev_i;
            o_out_q <= w_sh_q[SAMPLE_WIDTH-1:0] + r_prev_q;
            o_last  <= r_last;
        end
    end

    assign o_valid = r_out_valid;

endmodule

FILE: rtl/linear_fractional_resampler_unit.sv
// Top level of the linear fractional resampler for complex I/Q streams.
//
// Usage:
//  - s_axis carries one I/Q sample per request; tuser is the restart flag.
//    A restart clears phase and history, and that sample only primes.
//    The first sample after reset likewise only primes and gives nothing.
//  - m_axis carries interpolated samples; tlast marks the last output
//    produced by one input sample. An input may produce zero outputs.
//  - cfg channel writes phase_step (unsigned Q2.30); always ready, and
//    meant to be written only while the block is idle. Steps below 1/16
//    act as 1/16, so one input gives at most 16 outputs.
//  - Path: a job passes the front and the queue, then the back unit
//    forms each output by weight/multiply, then round/emit.
//  - Overlap: the back unit starts the next output only once the last
//    one is loaded into the output register; the queue takes inputs meanwhile.
//  - Reset clears phase, history, priming and the queue, and loads step 1.0.
//  - A stall on m_axis holds the output register; the queue keeps taking
//    inputs until it fills, then s_axis_tready drops.
module linear_fractional_resampler_unit #(
    parameter int SAMPLE_WIDTH = 16
) (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // input samples
    input  logic                               s_axis_tvalid,
    output logic                               s_axis_tready,
    input  logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] s_axis_tdata,  // sample_i, sample_q
    input  logic                               s_axis_tuser,  // restart
    // output samples
    output logic                               m_axis_tvalid,
    input  logic                               m_axis_tready,
    output logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,  // out_i, out_q
    output logic                               m_axis_tlast,  // run_last
    // phase_step write
    input  logic                               i_cfg_valid,
    output logic                               o_cfg_ready,
    input  logic [lfr_pkg::STEP_WIDTH-1:0]     i_cfg_data
);
    import lfr_pkg::*;

    localparam int DATA_W = ((2*SAMPLE_WIDTH + 7) / 8) * 8;
    localparam int PAD_W  = DATA_W - 2*SAMPLE_WIDTH;
    localparam int JOB_W  = 4*SAMPLE_WIDTH + 1;

    t_queue_status                  w_qstat;
    logic                           w_push, w_pop;
    logic [JOB_W-1:0]               w_job_in, w_job_out;
    logic signed [SAMPLE_WIDTH-1:0] w_out_i, w_out_q;
    logic [DATA_W-1:0]              w_out_data;

    assign o_cfg_ready = 1'b1;

    lfr_front #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .JOB_WIDTH    (JOB_W)
    ) u_front (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_valid        (s_axis_tvalid),
        .o_ready        (s_axis_tready),
        .i_sample_i     (s_axis_tdata[0 +: SAMPLE_WIDTH]),
        .i_sample_q     (s_axis_tdata[SAMPLE_WIDTH +: SAMPLE_WIDTH]),
        .i_restart      (s_axis_tuser),
        .i_queue_status (w_qstat),
        .o_push         (w_push),
        .o_job          (w_job_in)
    );

    lfr_job_queue #(
        .WIDTH (JOB_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_push   (w_push),
        .i_data   (w_job_in),
        .i_pop    (w_pop),
        .o_data   (w_job_out),
        .o_status (w_qstat)
    );

    lfr_back #(
        .SAMPLE_WIDTH (SAMPLE_WIDTH),
        .JOB_WIDTH    (JOB_W)
    ) u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg_we       (i_cfg_valid),
        .i_cfg_data     (i_cfg_data),
        .i_queue_status (w_qstat),
        .i_job          (w_job_out),
        .o_pop          (w_pop),
        .o_valid        (m_axis_tvalid),
        .i_ready        (m_axis_tready),
        .o_out_i        (w_out_i),
        .o_out_q        (w_out_q),
        .o_last         (m_axis_tlast)
    );

    // zero fill above the two rails
    always_comb begin
        w_out_data = '0;
        w_out_data[0 +: SAMPLE_WIDTH]            = w_out_i;
        w_out_data[SAMPLE_WIDTH +: SAMPLE_WIDTH] = w_out_q;
    end

    assign m_axis_tdata = w_out_data;

    if (PAD_W < 0) begin : g_bad_width
        $error("data width too narrow");
    end

endmodule

FILE: rtl/lfr_checker.sv
// Port-level assertions for the resampler, bound to the top level.
module lfr_checker #(
    parameter int SAMPLE_WIDTH = 16
) (
    input logic                                i_clk,
    input logic                                i_rst_n,
    input logic                                s_axis_tready,
    input logic                                m_axis_tvalid,
    input logic                                m_axis_tready,
    input logic [((2*SAMPLE_WIDTH+7)/8)*8-1:0] m_axis_tdata,
    input logic                                m_axis_tlast,
    input logic                                i_cfg_valid,
    input logic                                o_cfg_ready
);

    // stalled output holds its payload
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
        else $error("output changed while stalled");

    // queue comes out of reset empty, so the input side is open
    a_reset_open: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // nothing leaves the block right after reset
    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output valid after reset");

    // config port never stalls
    a_cfg_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cfg_valid |-> o_cfg_ready)
        else $error("config write stalled");

endmodule

bind linear_fractional_resampler_unit lfr_checker #(
    .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_lfr_checker (.*);
